FILE: hw/rtl/admc_pkg.sv
// Package for the audio driven media clock: field widths, the tick rate,
// action and register codes. No dependencies.
package admc_pkg;

  localparam int unsigned TICKS_PER_SEC = 10000000;
  localparam int TPS_W = $clog2(TICKS_PER_SEC + 1);

  localparam int ACTION_W   = 3;
  localparam int STAMP_W    = 63;
  localparam int FRAMES_W   = 32;
  localparam int REL_W      = 64;
  localparam int RATE_W     = 32;
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 2;

  // Partial product of one 32-bit slice and the tick rate.
  localparam int MUL_P_W = FRAMES_W + TPS_W;
  // Full product of a stamp difference and the tick rate.
  localparam int PROD_W  = STAMP_W + TPS_W;
  localparam int CNT_W   = $clog2(PROD_W + 1);

  localparam logic [STAMP_W-1:0] TIME_MAX = {STAMP_W{1'b1}};
  localparam logic [REL_W-1:0]   REL_MIN  = {1'b1, {(REL_W-1){1'b0}}};
  localparam logic [REL_W-1:0]   REL_MAX  = {1'b0, {(REL_W-1){1'b1}}};

  localparam logic [RATE_W-1:0]     SAMPLE_RATE_RST  = RATE_W'(48000);
  localparam logic [CFG_DATA_W-1:0] COUNTER_FREQ_RST = CFG_DATA_W'(10000000);

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 3'd0,
    ACT_RESET   = 3'd1,
    ACT_PAUSE   = 3'd2,
    ACT_RESUME  = 3'd3,
    ACT_ADVANCE = 3'd4,
    ACT_QUERY   = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE  = 2'd0,
    CFG_COUNTER_FREQ = 2'd1
  } cfg_reg_t;

endpackage

FILE: hw/rtl/admc_in_if.sv
// Input channel of the audio driven media clock: valid, ready and one item.
// Depends on admc_pkg.
interface admc_in_if import admc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [STAMP_W-1:0]  start_stamp;
  logic [FRAMES_W-1:0] frame_count;
  logic [STAMP_W-1:0]  query_stamp;

  modport source (output valid, action, start_stamp, frame_count, query_stamp,
                  input ready);
  modport sink   (input valid, action, start_stamp, frame_count, query_stamp,
                  output ready);
endinterface

FILE: hw/rtl/admc_out_if.sv
// Result channel of the audio driven media clock: valid, ready and one result.
// Depends on admc_pkg.
interface admc_out_if import admc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAMP_W-1:0]      current_time;
  logic [STAMP_W-1:0]      start_now;
  logic signed [REL_W-1:0] relative_time;
  logic                    running;
  logic                    paused;

  modport source (output valid, current_time, start_now, relative_time, running, paused,
                  input ready);
  modport sink   (input valid, current_time, start_now, relative_time, running, paused,
                  output ready);
endinterface

FILE: hw/rtl/audio_driven_media_clock.sv
// Audio driven media clock: timeline state, command sequencer, one shared
// multiplier and a bit-serial divider. Depends on admc_pkg, admc_in_if, admc_out_if.
//
//   channel   | direction | beat
//   ----------+-----------+---------------------------------------------------
//   item      | in        | action, start_stamp, frame_count, query_stamp
//   result    | out       | current_time, start_now, relative_time, running, paused
//   cfg       | in        | cfg_we, cfg_index, cfg_data (sample_rate, counter_frequency)
//
// Start, reset, pause, resume and skipped commands go from accept straight to the finishing step.
// An advance takes one multiply, then 56 divide steps of the shared
// subtract-and-compare unit. A query takes two multiply slices, then 87 steps.
// Item ready is high only while the sequencer is idle; a result waits in the output
// register, and a later result waits in the last step until that register is free.
// Reset is synchronous and restores the register defaults and a stopped clock.
module audio_driven_media_clock import admc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  admc_in_if.sink               item,
  admc_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration and timeline state.
  logic [RATE_W-1:0]     sample_rate;
  logic [CFG_DATA_W-1:0] counter_frequency;
  logic [STAMP_W-1:0]    time_accum;
  logic [STAMP_W-1:0]    start_latch;
  logic                  run_flag;
  logic                  pause_flag;

  // Item being worked on.
  action_t               act;
  logic [STAMP_W-1:0]    new_start;
  logic [FRAMES_W-1:0]   frames;
  logic [STAMP_W-1:0]    mag;
  logic                  neg;

  // Shared arithmetic.
  logic [PROD_W-1:0]     prod;
  logic [CNT_W-1:0]      cnt;
  logic [STAMP_W-1:0]    rem;
  logic [REL_W-1:0]      quo;
  logic                  big;

  logic                  accept;
  logic                  out_free;
  action_t               in_act;
  logic                  needs_math;
  logic [STAMP_W-1:0]    div_d;
  logic [FRAMES_W-1:0]   mul_a;
  logic [MUL_P_W-1:0]    mul_p;
  logic [REL_W-1:0]      trial;
  logic [REL_W-1:0]      trial_diff;
  logic                  trial_ge;
  logic [STAMP_W-1:0]    rem_next;
  logic [REL_W-1:0]      sum;

  logic [STAMP_W-1:0]    time_accum_next;
  logic [STAMP_W-1:0]    start_latch_next;
  logic                  run_flag_next;
  logic                  pause_flag_next;
  logic [REL_W-1:0]      rel_next;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;
  assign in_act     = action_t'(item.action);

  always_comb begin
    needs_math = 1'b0;
    case (in_act)
      ACT_ADVANCE: needs_math = run_flag && !pause_flag;
      ACT_QUERY:   needs_math = (start_latch != '0);
      default:     needs_math = 1'b0;
    endcase
  end

  // A zero rate or frequency divides as one.
  always_comb begin
    if (act == ACT_ADVANCE) begin
      div_d = (sample_rate == '0) ? STAMP_W'(1) : STAMP_W'(sample_rate);
    end else begin
      div_d = (counter_frequency == '0) ? STAMP_W'(1) : counter_frequency;
    end
  end

  // One 32-bit slice times the tick rate; the upper stamp slice has 31 bits.
  always_comb begin
    if (act == ACT_ADVANCE) begin
      mul_a = frames;
    end else if (state == S_MUL_HI) begin
      mul_a = FRAMES_W'(mag[STAMP_W-1:FRAMES_W]);
    end else begin
      mul_a = mag[FRAMES_W-1:0];
    end
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(TICKS_PER_SEC);

  // Restoring divide step: the next dividend bit comes off the top of prod.
  assign trial      = {rem, prod[PROD_W-1]};
  assign trial_diff = trial - {1'b0, div_d};
  assign trial_ge   = (trial >= {1'b0, div_d});
  assign rem_next   = trial_ge ? trial_diff[STAMP_W-1:0] : trial[STAMP_W-1:0];

  assign sum = {1'b0, time_accum} + {1'b0, quo[STAMP_W-1:0]};

  always_comb begin
    time_accum_next  = time_accum;
    start_latch_next = start_latch;
    run_flag_next    = run_flag;
    pause_flag_next  = pause_flag;
    rel_next         = '0;
    unique case (act)
      ACT_START: begin
        start_latch_next = new_start;
        time_accum_next  = '0;
        run_flag_next    = 1'b1;
        pause_flag_next  = 1'b0;
      end
      ACT_RESET: begin
        start_latch_next = '0;
        time_accum_next  = '0;
        run_flag_next    = 1'b0;
        pause_flag_next  = 1'b0;
      end
      ACT_PAUSE: begin
        if (run_flag) begin
          pause_flag_next = 1'b1;
        end
      end
      ACT_RESUME: begin
        if (run_flag && pause_flag) begin
          pause_flag_next = 1'b0;
        end
      end
      ACT_ADVANCE: begin
        if (run_flag && !pause_flag) begin
          if (quo[REL_W-1] || sum[REL_W-1]) begin
            time_accum_next = TIME_MAX;
          end else begin
            time_accum_next = sum[STAMP_W-1:0];
          end
        end
      end
      ACT_QUERY: begin
        if (start_latch != '0) begin
          if (neg) begin
            rel_next = (big || quo > REL_MIN) ? REL_MIN : (REL_W'(0) - quo);
          end else begin
            rel_next = (big || quo[REL_W-1]) ? REL_MAX : quo;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sample_rate       <= SAMPLE_RATE_RST;
      counter_frequency <= COUNTER_FREQ_RST;
      time_accum        <= '0;
      start_latch       <= '0;
      run_flag          <= 1'b0;
      pause_flag        <= 1'b0;
      result.valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SAMPLE_RATE:  sample_rate       <= cfg_data[RATE_W-1:0];
          CFG_COUNTER_FREQ: counter_frequency <= cfg_data;
          default: ;
        endcase
      end

      // A beat taken during the finishing step is replaced there by the next one.
      if (result.valid && result.ready && state != S_FINISH) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act       <= in_act;
            new_start <= item.start_stamp;
            frames    <= item.frame_count;
            neg       <= (item.query_stamp < start_latch);
            mag       <= (item.query_stamp < start_latch) ?
                         (start_latch - item.query_stamp) :
                         (item.query_stamp - start_latch);
            rem       <= '0;
            quo       <= '0;
            big       <= 1'b0;
            state     <= needs_math ? S_MUL_LO : S_FINISH;
          end
        end
        S_MUL_LO: begin
          if (act == ACT_ADVANCE) begin
            // Left-align so only the product's own bits go through the divider.
            prod  <= {mul_p, {(PROD_W - MUL_P_W){1'b0}}};
            cnt   <= CNT_W'(MUL_P_W);
            state <= S_DIVIDE;
          end else begin
            prod  <= PROD_W'(mul_p);
            state <= S_MUL_HI;
          end
        end
        S_MUL_HI: begin
          prod  <= prod + PROD_W'({mul_p, {FRAMES_W{1'b0}}});
          cnt   <= CNT_W'(PROD_W);
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          prod  <= {prod[PROD_W-2:0], 1'b0};
          rem   <= rem_next;
          quo   <= {quo[REL_W-2:0], trial_ge};
          big   <= big || quo[REL_W-1];
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            time_accum           <= time_accum_next;
            start_latch          <= start_latch_next;
            run_flag             <= run_flag_next;
            pause_flag           <= pause_flag_next;
            result.valid         <= 1'b1;
            result.current_time  <= time_accum_next;
            result.start_now     <= start_latch_next;
            result.relative_time <= rel_next;
            result.running       <= run_flag_next;
            result.paused        <= pause_flag_next;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pause_needs_run: assert property (@(posedge clk) disable iff (rst)
    pause_flag |-> run_flag)
    else $error("paused while the clock is not running");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (rem < div_d && cnt != '0))
    else $error("divider remainder or step count out of range");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_FINISH))
    else $error("result beat raised outside the finishing step");

  a_advance_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && act == ACT_ADVANCE) |-> !big)
    else $error("advance quotient overflowed the divider");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> !$past(accept))
    else $error("item accepted while the sequencer was busy");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for audio_driven_media_clock: it drives command beats,
// predicts every result beat from its own timeline model and checks each field.
// Depends on admc_pkg, admc_in_if, admc_out_if and the block itself.
module tb_top;
  import admc_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 600000;
  localparam int unsigned HOLD_CYCLES       = 300;
  localparam int unsigned TAIL_CYCLES       = 120;
  localparam int unsigned SEGMENT_ITEMS     = 110;
  localparam int unsigned SATURATE_ADVANCES = 218;

  localparam logic [ACTION_W-1:0]  ACT_UNUSED_LO     = 3'd6;
  localparam logic [ACTION_W-1:0]  ACT_UNUSED_HI     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 2'd3;
  localparam logic [FRAMES_W-1:0]  FRAMES_MAX        = '1;

  typedef struct {
    logic [STAMP_W-1:0]      current_time;
    logic [STAMP_W-1:0]      start_now;
    logic signed [REL_W-1:0] relative_time;
    logic                    running;
    logic                    paused;
  } timeline_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  admc_in_if  item_ch ();
  admc_out_if result_ch ();

  audio_driven_media_clock dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted timeline state and our copy of the two registers.
  logic [STAMP_W-1:0]    tl_time;
  logic [STAMP_W-1:0]    tl_start;
  logic                  tl_running;
  logic                  tl_paused;
  logic [RATE_W-1:0]     rate_reg;
  logic [CFG_DATA_W-1:0] freq_reg;

  timeline_t   expected_results[$];
  int unsigned errors        = 0;
  int unsigned cycle_count   = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_requests = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Applies one command to the predicted timeline and returns the result beat.
  function automatic timeline_t step_timeline(input logic [ACTION_W-1:0] act,
                                              input logic [STAMP_W-1:0]  s_stamp,
                                              input logic [FRAMES_W-1:0] frames,
                                              input logic [STAMP_W-1:0]  q_stamp);
    timeline_t          r;
    logic               neg;
    logic [STAMP_W-1:0] mag;
    logic [63:0]        rate;
    logic [63:0]        gained;
    logic [127:0]       product;
    logic [127:0]       divisor;
    logic [127:0]       quotient;
    r.relative_time = '0;
    case (act)
      ACT_START: begin
        tl_start   = s_stamp;
        tl_time    = '0;
        tl_running = 1'b1;
        tl_paused  = 1'b0;
      end
      ACT_RESET: begin
        tl_start   = '0;
        tl_time    = '0;
        tl_running = 1'b0;
        tl_paused  = 1'b0;
      end
      ACT_PAUSE: begin
        if (tl_running) tl_paused = 1'b1;
      end
      ACT_RESUME: begin
        if (tl_running && tl_paused) tl_paused = 1'b0;
      end
      ACT_ADVANCE: begin
        if (tl_running && !tl_paused) begin
          rate   = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
          gained = (64'(frames) * 64'(TICKS_PER_SEC)) / rate;
          // The position sticks at its maximum instead of wrapping.
          if (gained > 64'(TIME_MAX) - 64'(tl_time)) begin
            tl_time = TIME_MAX;
          end else begin
            tl_time = tl_time + gained[STAMP_W-1:0];
          end
        end
      end
      ACT_QUERY: begin
        // With no start stamp latched the answer stays zero.
        if (tl_start != '0) begin
          neg      = q_stamp < tl_start;
          mag      = neg ? tl_start - q_stamp : q_stamp - tl_start;
          product  = 128'(mag) * 128'(TICKS_PER_SEC);
          divisor  = (freq_reg == '0) ? 128'd1 : 128'(freq_reg);
          quotient = product / divisor;
          if (neg) begin
            r.relative_time = (quotient > 128'(REL_MIN)) ? REL_MIN :
                              {REL_W{1'b0}} - quotient[REL_W-1:0];
          end else begin
            r.relative_time = (quotient > 128'(REL_MAX)) ? REL_MAX : quotient[REL_W-1:0];
          end
        end
      end
      default: ;
    endcase
    r.current_time = tl_time;
    r.start_now    = tl_start;
    r.running      = tl_running;
    r.paused       = tl_paused;
    return r;
  endfunction

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(5))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return STAMP_W'($urandom_range(1000, 1));
      3:       return tl_start + STAMP_W'($urandom_range(100000000));
      4:       return tl_start - STAMP_W'($urandom_range(100000000));
      default: return STAMP_W'({$urandom, $urandom});
    endcase
  endfunction

  // Offers one command beat and records its prediction once it is taken.
  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic [STAMP_W-1:0]  s_stamp,
                           input logic [FRAMES_W-1:0] frames,
                           input logic [STAMP_W-1:0]  q_stamp);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= act;
    item_ch.start_stamp <= s_stamp;
    item_ch.frame_count <= frames;
    item_ch.query_stamp <= q_stamp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    expected_results.push_back(step_timeline(act, s_stamp, frames, q_stamp));
  endtask

  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SAMPLE_RATE:  rate_reg = data[RATE_W-1:0];
      CFG_COUNTER_FREQ: freq_reg = data;
      default: ;
    endcase
  endtask

  task automatic test_idle_commands();
    send_item(ACT_QUERY, '0, '0, TIME_MAX);
    send_item(ACT_ADVANCE, '0, FRAMES_MAX, '0);
    send_item(ACT_PAUSE, '0, '0, '0);
    send_item(ACT_RESUME, '0, '0, '0);
    send_item(ACT_UNUSED_LO, TIME_MAX, FRAMES_MAX, TIME_MAX);
    send_item(ACT_UNUSED_HI, TIME_MAX, FRAMES_MAX, TIME_MAX);
  endtask

  task automatic test_start_and_advance();
    send_item(ACT_START, TIME_MAX, '0, '0);
    send_item(ACT_QUERY, '0, '0, '0);
    send_item(ACT_QUERY, '0, '0, TIME_MAX);
    send_item(ACT_ADVANCE, '0, FRAMES_MAX, '0);
    send_item(ACT_ADVANCE, '0, '0, '0);
    send_item(ACT_PAUSE, '0, '0, '0);
    send_item(ACT_ADVANCE, '0, 32'd1000, '0);
    send_item(ACT_PAUSE, '0, '0, '0);
    send_item(ACT_RESUME, '0, '0, '0);
    send_item(ACT_RESUME, '0, '0, '0);
    send_item(ACT_ADVANCE, '0, 32'd48000, '0);
  endtask

  task automatic test_reset_command();
    send_item(ACT_START, 63'd1, '0, '0);
    send_item(ACT_QUERY, '0, '0, TIME_MAX);
    send_item(ACT_UNUSED_HI, TIME_MAX, FRAMES_MAX, TIME_MAX);
    send_item(ACT_RESET, TIME_MAX, FRAMES_MAX, TIME_MAX);
    send_item(ACT_QUERY, '0, '0, 63'd12345);
    send_item(ACT_ADVANCE, '0, 32'd480, '0);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_SAMPLE_RATE, 63'd1);
    write_reg(CFG_COUNTER_FREQ, 63'd1);
    send_item(ACT_START, 63'd1, '0, '0);
    send_item(ACT_QUERY, '0, '0, TIME_MAX);
    send_item(ACT_START, TIME_MAX, '0, '0);
    send_item(ACT_QUERY, '0, '0, '0);
    send_item(ACT_ADVANCE, '0, FRAMES_MAX, '0);
    // All ones: the sample rate keeps only its low 32 bits.
    write_reg(CFG_SAMPLE_RATE, '1);
    write_reg(CFG_COUNTER_FREQ, TIME_MAX);
    send_item(ACT_ADVANCE, '0, FRAMES_MAX, '0);
    send_item(ACT_QUERY, '0, '0, '0);
    write_reg(CFG_IDX_UNUSED_LO, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(CFG_IDX_UNUSED_HI, CFG_DATA_W'({$urandom, $urandom}));
    send_item(ACT_ADVANCE, '0, FRAMES_MAX, '0);
    send_item(ACT_QUERY, '0, '0, '0);
  endtask

  // A zero rate counts as one, so each full advance adds the most ticks possible.
  task automatic test_time_saturation();
    write_reg(CFG_SAMPLE_RATE, '0);
    write_reg(CFG_COUNTER_FREQ, '0);
    send_item(ACT_START, STAMP_W'({$urandom, $urandom}) | 63'd1, '0, '0);
    send_item(ACT_QUERY, '0, '0, tl_start + 63'd5);
    repeat (SATURATE_ADVANCES) send_item(ACT_ADVANCE, pick_stamp(), FRAMES_MAX, pick_stamp());
    send_item(ACT_QUERY, '0, '0, pick_stamp());
    send_item(ACT_PAUSE, '0, '0, '0);
    send_item(ACT_ADVANCE, '0, FRAMES_MAX, '0);
    send_item(ACT_RESUME, '0, '0, '0);
    send_item(ACT_ADVANCE, '0, 32'd1, '0);
  endtask

  task automatic test_random_traffic();
    logic [ACTION_W-1:0] act;
    logic [FRAMES_W-1:0] frames;
    int unsigned         roll;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin
          tx_idle_pct = 23;
          rx_idle_pct = 67;
          write_reg(CFG_SAMPLE_RATE, 63'd48000);
          write_reg(CFG_COUNTER_FREQ, 63'd10000000);
        end
        1: begin
          tx_idle_pct = 67;
          rx_idle_pct = 23;
          write_reg(CFG_SAMPLE_RATE, 63'd44100);
          write_reg(CFG_COUNTER_FREQ, 63'd19200000);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'({$urandom, $urandom}));
          write_reg(CFG_COUNTER_FREQ, CFG_DATA_W'({$urandom, $urandom}));
        end
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 7) act = ACT_START;
        else if (roll < 10) act = ACT_RESET;
        else if (roll < 16) act = ACT_PAUSE;
        else if (roll < 26) act = ACT_RESUME;
        else if (roll < 62) act = ACT_ADVANCE;
        else if (roll < 96) act = ACT_QUERY;
        else if (roll < 98) act = ACT_UNUSED_LO;
        else act = ACT_UNUSED_HI;
        case ($urandom_range(3))
          0:       frames = '0;
          1:       frames = FRAMES_MAX;
          2:       frames = FRAMES_W'($urandom_range(4800, 1));
          default: frames = FRAMES_W'($urandom);
        endcase
        send_item(act, pick_stamp(), frames, pick_stamp());
      end
    end
  endtask

  // The receiver stalls for a long stretch while beats keep coming, so the
  // block backs up and drops its input ready.
  task automatic test_backpressure();
    write_reg(CFG_SAMPLE_RATE, 63'd48000);
    write_reg(CFG_COUNTER_FREQ, 63'd10000000);
    send_item(ACT_START, STAMP_W'({$urandom, $urandom}), '0, '0);
    hold_requests++;
    for (int n = 0; n < 8; n++) begin
      if (n % 2 == 0) send_item(ACT_ADVANCE, '0, FRAMES_W'($urandom_range(4800, 1)), '0);
      else send_item(ACT_QUERY, '0, '0, pick_stamp());
    end
    wait_drained();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    timeline_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no prediction pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.current_time !== want.current_time) begin
          $error("current_time: expected %0d, got %0d", want.current_time,
                 result_ch.current_time);
          errors++;
        end
        if (result_ch.start_now !== want.start_now) begin
          $error("start_now: expected %0d, got %0d", want.start_now, result_ch.start_now);
          errors++;
        end
        if (result_ch.relative_time !== want.relative_time) begin
          $error("relative_time: expected %0d, got %0d", want.relative_time,
                 result_ch.relative_time);
          errors++;
        end
        if (result_ch.running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, result_ch.running);
          errors++;
        end
        if (result_ch.paused !== want.paused) begin
          $error("paused: expected %0d, got %0d", want.paused, result_ch.paused);
          errors++;
        end
      end
    end
  end

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.action      <= '0;
    item_ch.start_stamp <= '0;
    item_ch.frame_count <= '0;
    item_ch.query_stamp <= '0;
    rate_reg   = SAMPLE_RATE_RST;
    freq_reg   = COUNTER_FREQ_RST;
    tl_time    = '0;
    tl_start   = '0;
    tl_running = 1'b0;
    tl_paused  = 1'b0;
    tx_idle_pct = 23;
    rx_idle_pct = 67;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_start_and_advance();
    test_reset_command();
    test_register_extremes();
    test_time_saturation();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
